// File: rtl/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// wsfd_pkg
// Types and constants shared by the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsfd_pkg;

	localparam int unsigned MAX_PAYLOAD = 125;

	localparam logic [6:0] LEN_EXTENDED = 7'd126;
	localparam logic [6:0] LEN_MAX      = 7'(MAX_PAYLOAD);

	localparam logic [3:0] OPC_TEXT  = 4'h1;
	localparam logic [3:0] OPC_CLOSE = 4'h8;

	typedef enum logic [2:0] {
		PH_HDR0 = 3'd0,
		PH_HDR1 = 3'd1,
		PH_KEY  = 3'd2,
		PH_DATA = 3'd3,
		PH_DONE = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FINAL = 3'd1,
		ST_RESERVED  = 3'd2,
		ST_BAD_OPC   = 3'd3,
		ST_UNMASKED  = 3'd4,
		ST_TOO_LONG  = 3'd5
	} status_t;

	localparam logic KIND_TEXT  = 1'b0;
	localparam logic KIND_CLOSE = 1'b1;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       has_byte;
		logic       last_of_frame;
		logic       frame_kind;
		status_t    status;
	} wsfd_res_t;

endpackage

// File: rtl/websocket_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// Client-to-server WebSocket deframer: header check, key capture, unmasking.
// ----------------------------------------------------------------------------
// Pipeline: an accepted input request passes the input register, then its
//   result reaches the master side from the result register.
// Throughput: one byte per cycle while the master side does not stall; the
//   parser state updates between the input register and the result register.
// Reset: arst_n clears all control state; the parser waits for header byte 0.
module websocket_frame_deframer_unit
	import wsfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// slave side: incoming stream bytes
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	// master side: deframed results
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
	output logic       m_axis_tlast,   // last_of_frame
	output logic [4:0] m_axis_tuser    // [0] has_byte, [1] frame_kind, [4:2] status
);

	// input register
	logic       vld_s1;
	logic [7:0] data_s1;

	// parser state
	phase_t      phase_q;
	logic [31:0] mask_key_q;
	logic [6:0]  bytes_left_q;
	logic [1:0]  key_pos_q;
	logic        kind_q;
	logic        stopped_q;

	// result register
	logic      out_vld_q;
	wsfd_res_t res_q;

	// next-state values
	phase_t      phase_d;
	logic [31:0] mask_key_d;
	logic [6:0]  bytes_left_d;
	logic [1:0]  key_pos_d;
	logic        kind_d;
	logic        stopped_d;
	logic        res_vld;
	wsfd_res_t   res_d;

	logic room;
	logic adv;

	// The result register is free when empty or being drained this cycle.
	assign room          = !out_vld_q || m_axis_tready;
	assign adv           = vld_s1 && room;
	assign s_axis_tready = !vld_s1 || room;

	// Input register: take a fresh request, or drop the one just processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			data_s1 <= s_axis_tdata;
		end
	end

	// Frame parser: one byte of the stream per processed request.
	always_comb begin
		phase_d      = phase_q;
		mask_key_d   = mask_key_q;
		bytes_left_d = bytes_left_q;
		key_pos_d    = key_pos_q;
		kind_d       = kind_q;
		stopped_d    = stopped_q;
		res_vld      = 1'b0;
		res_d        = '{payload_byte: 8'h00, has_byte: 1'b0, last_of_frame: 1'b0,
		                 frame_kind: KIND_TEXT, status: ST_OK};

		if (!stopped_q) begin
			case (phase_q)
				PH_HDR1: begin
					res_d.frame_kind    = kind_q;
					res_d.last_of_frame = 1'b1;
					if (!data_s1[7]) begin
						// unmasked client frame: report and halt
						res_vld      = 1'b1;
						res_d.status = ST_UNMASKED;
						stopped_d    = 1'b1;
					end else if (data_s1[6:0] >= LEN_EXTENDED || data_s1[6:0] > LEN_MAX) begin
						res_vld      = 1'b1;
						res_d.status = ST_TOO_LONG;
						stopped_d    = 1'b1;
					end else begin
						bytes_left_d = data_s1[6:0];
						mask_key_d   = '0;
						key_pos_d    = 2'd0;
						phase_d      = PH_KEY;
					end
				end
				PH_KEY: begin
					mask_key_d[{key_pos_q, 3'b000} +: 8] = data_s1;
					key_pos_d = key_pos_q + 2'd1;
					if (key_pos_q == 2'd3) begin
						if (bytes_left_q == 7'd0) begin
							// empty frame: one last-marked result without a byte
							res_vld             = 1'b1;
							res_d.last_of_frame = 1'b1;
							res_d.frame_kind    = kind_q;
							phase_d             = kind_q ? PH_DONE : PH_HDR0;
						end else begin
							phase_d = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					res_vld            = 1'b1;
					res_d.payload_byte = data_s1 ^ mask_key_q[{key_pos_q, 3'b000} +: 8];
					res_d.has_byte     = 1'b1;
					res_d.frame_kind   = kind_q;
					key_pos_d          = key_pos_q + 2'd1;
					bytes_left_d       = bytes_left_q - 7'd1;
					if (bytes_left_q == 7'd1) begin
						res_d.last_of_frame = 1'b1;
						phase_d             = kind_q ? PH_DONE : PH_HDR0;
					end
				end
				PH_DONE: begin
					// after a close frame: drop everything
				end
				default: begin
					// header byte 0 (unused codes land here too)
					res_d.last_of_frame = 1'b1;
					if (!data_s1[7]) begin
						res_vld      = 1'b1;
						res_d.status = ST_NOT_FINAL;
						stopped_d    = 1'b1;
					end else if (data_s1[6:4] != 3'b000) begin
						res_vld      = 1'b1;
						res_d.status = ST_RESERVED;
						stopped_d    = 1'b1;
					end else if (data_s1[3:0] == OPC_TEXT) begin
						kind_d  = KIND_TEXT;
						phase_d = PH_HDR1;
					end else if (data_s1[3:0] == OPC_CLOSE) begin
						kind_d  = KIND_CLOSE;
						phase_d = PH_HDR1;
					end else begin
						res_vld      = 1'b1;
						res_d.status = ST_BAD_OPC;
						stopped_d    = 1'b1;
					end
				end
			endcase
		end
	end

	// Parser state: advance only when a request leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HDR0;
			mask_key_q   <= '0;
			bytes_left_q <= '0;
			key_pos_q    <= '0;
			kind_q       <= KIND_TEXT;
			stopped_q    <= 1'b0;
		end else if (adv) begin
			phase_q      <= phase_d;
			mask_key_q   <= mask_key_d;
			bytes_left_q <= bytes_left_d;
			key_pos_q    <= key_pos_d;
			kind_q       <= kind_d;
			stopped_q    <= stopped_d;
		end
	end

	// Result register: hold until taken, load on every processed request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= res_vld;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = res_q.payload_byte;
	assign m_axis_tlast  = res_q.last_of_frame;
	assign m_axis_tuser  = {res_q.status, res_q.frame_kind, res_q.has_byte};

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives a client WebSocket byte stream into websocket_frame_deframer_unit.
// A scoreboard object tracks the parser state. It predicts every unmasked
// payload byte, every empty-frame marker and every header error. It checks
// each result on the master side in order. The stream runs directed frames,
// then random text frames until 720 bytes or more. It ends with a terminal
// event (a close frame or a header error) picked at random, then trailing noise.
// Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
	import wsfd_pkg::*;

	localparam logic [7:0] FIN_BIT   = 8'h80;
	localparam logic [7:0] MASK_BIT  = 8'h80;
	localparam int         RUN_LIMIT = 200000;
	localparam int         REPORT_MAX = 10;

	typedef enum int {
		END_CLOSE,
		END_NOT_FINAL,
		END_RESERVED,
		END_BAD_OPC,
		END_UNMASKED,
		END_TOO_LONG
	} ending_t;

	// payload fill patterns
	localparam int FILL_RANDOM = 0;
	localparam int FILL_ZERO   = 1;
	localparam int FILL_TOGGLE = 2;

	// ------------------------------------------------------------------
	// Scoreboard: mirror of the deframer state plus the results owed
	// ------------------------------------------------------------------
	class deframe_ledger;
		phase_t      ph;
		logic [31:0] key;
		logic [6:0]  left;
		logic [1:0]  kpos;
		logic        kind;
		logic        halted;
		wsfd_res_t   owed[$];
		int          requests;
		int          results;
		int          mismatches;

		function new();
			ph = PH_HDR0;
			key = '0;
			left = '0;
			kpos = '0;
			kind = KIND_TEXT;
			halted = 1'b0;
			requests = 0;
			results = 0;
			mismatches = 0;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		// Advance the mirror by one accepted stream byte; queue any result.
		function void note_request(logic [7:0] b);
			wsfd_res_t r;
			logic      got;
			logic [7:0] v;
			r = '0;
			got = 1'b0;
			requests++;
			if (halted || ph == PH_DONE)
				return;
			case (ph)
				PH_HDR1: begin
					if ((b & MASK_BIT) == 8'h00) begin
						r.status = ST_UNMASKED;
						got = 1'b1;
					end else if (b[6:0] >= LEN_EXTENDED || b[6:0] > LEN_MAX) begin
						r.status = ST_TOO_LONG;
						got = 1'b1;
					end else begin
						left = b[6:0];
						key = '0;
						kpos = '0;
						ph = PH_KEY;
					end
					if (got) begin
						r.last_of_frame = 1'b1;
						r.frame_kind = kind;
						halted = 1'b1;
					end
				end
				PH_KEY: begin
					key[{kpos, 3'b000} +: 8] = b;
					if (kpos == 2'd3) begin
						kpos = '0;
						if (left == '0) begin
							// empty frame: one bare marker
							r.last_of_frame = 1'b1;
							r.frame_kind = kind;
							r.status = ST_OK;
							got = 1'b1;
							ph = (kind == KIND_CLOSE) ? PH_DONE : PH_HDR0;
						end else begin
							ph = PH_DATA;
						end
					end else begin
						kpos = kpos + 2'd1;
					end
				end
				PH_DATA: begin
					v = b ^ key[{kpos, 3'b000} +: 8];
					kpos = kpos + 2'd1;
					left = left - 7'd1;
					r.payload_byte = v;
					r.has_byte = 1'b1;
					r.last_of_frame = (left == '0);
					r.frame_kind = kind;
					r.status = ST_OK;
					got = 1'b1;
					if (left == '0)
						ph = (kind == KIND_CLOSE) ? PH_DONE : PH_HDR0;
				end
				default: begin
					if ((b & FIN_BIT) == 8'h00) begin
						r.status = ST_NOT_FINAL;
						got = 1'b1;
					end else if (b[6:4] != 3'b000) begin
						r.status = ST_RESERVED;
						got = 1'b1;
					end else if (b[3:0] == OPC_TEXT) begin
						kind = KIND_TEXT;
						ph = PH_HDR1;
					end else if (b[3:0] == OPC_CLOSE) begin
						kind = KIND_CLOSE;
						ph = PH_HDR1;
					end else begin
						r.status = ST_BAD_OPC;
						got = 1'b1;
					end
					if (got) begin
						r.last_of_frame = 1'b1;
						r.frame_kind = KIND_TEXT;
						halted = 1'b1;
					end
				end
			endcase
			if (got)
				owed.push_back(r);
		endfunction

		// Compare one accepted result against the oldest owed one.
		function void check_result(logic [7:0] pb, logic tl, logic [4:0] tu);
			wsfd_res_t e;
			results++;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("[%0t] unexpected result: byte=%02h last=%0b user=%05b",
						$realtime, pb, tl, tu);
				return;
			end
			e = owed.pop_front();
			if (e.payload_byte !== pb || e.has_byte !== tu[0] ||
					e.last_of_frame !== tl || e.frame_kind !== tu[1] ||
					e.status !== tu[4:2]) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display({"[%0t] result mismatch: expected byte=%02h has=%0b ",
						"last=%0b kind=%0b status=%0d, got byte=%02h has=%0b ",
						"last=%0b kind=%0b status=%0d"},
						$realtime, e.payload_byte, e.has_byte, e.last_of_frame,
						e.frame_kind, e.status, pb, tu[0], tl, tu[1], tu[4:2]);
			end
		endfunction
	endclass

	// ------------------------------------------------------------------
	// Clock, reset and the block
	// ------------------------------------------------------------------
	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;
	logic [4:0] m_axis_tuser;

	always #2 clk = ~clk;

	websocket_frame_deframer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	deframe_ledger ledger = new();
	logic          calm = 1'b0;   // when set, neither side idles
	int            stall_left = 0;
	int            cycles = 0;
	int            frames = 0;
	ending_t       ending;

	function automatic int draw_wait();
		if (calm)
			return 0;
		return $urandom_range(0, 8);
	endfunction

	// Mostly short frames, some medium, a few near the maximum.
	function automatic int draw_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(0, 12);
		if (r < 95)
			return $urandom_range(13, 60);
		return $urandom_range(61, MAX_PAYLOAD);
	endfunction

	function automatic logic [7:0] head0(logic close);
		return FIN_BIT | {4'h0, (close ? OPC_CLOSE : OPC_TEXT)};
	endfunction

	// ------------------------------------------------------------------
	// Result side: stall at random, check every accepted result
	// ------------------------------------------------------------------
	initial begin
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			ledger.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
			stall_left = draw_wait();
		end
		if (cycles > RUN_LIMIT) begin
			$display("[%0t] run limit of %0d cycles reached, %0d results still owed",
				$realtime, RUN_LIMIT, ledger.pending());
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------
	// Offer one byte after a random gap; hold until the handshake, then note it.
	// Called and left on a falling edge; tvalid stays high unless a gap follows.
	task automatic push_byte(input logic [7:0] b);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		ledger.note_request(b);
		@(negedge clk);
	endtask

	task automatic send_frame(input logic close, input int len, input logic [31:0] key,
			input int fill);
		int i;
		logic [7:0] pb;
		push_byte(head0(close));
		push_byte(MASK_BIT | 8'(len));
		for (i = 0; i < 4; i++)
			push_byte(key[8*i +: 8]);
		for (i = 0; i < len; i++) begin
			case (fill)
				FILL_ZERO:   pb = 8'h00;
				FILL_TOGGLE: pb = i[0] ? 8'hff : 8'h00;
				default:     pb = 8'($urandom);
			endcase
			push_byte(pb);
		end
		frames++;
	endtask

	// Drop tvalid and hold until every owed result has drained.
	task automatic drain_hold();
		s_axis_tvalid <= 1'b0;
		while (ledger.pending() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// Close the stream for good: a close frame or one kind of header error.
	task automatic finish_stream();
		logic [3:0] opc;
		case (ending)
			END_CLOSE:
				send_frame(1'b1, $urandom_range(0, 20), $urandom, FILL_RANDOM);
			END_NOT_FINAL:
				push_byte({1'b0, 7'($urandom)});
			END_RESERVED:
				push_byte({1'b1, 3'($urandom_range(1, 7)), 4'($urandom)});
			END_BAD_OPC: begin
				do opc = 4'($urandom); while (opc == OPC_TEXT || opc == OPC_CLOSE);
				push_byte({1'b1, 3'b000, opc});
			end
			END_UNMASKED: begin
				push_byte(head0(1'($urandom)));
				push_byte({1'b0, 7'($urandom)});
			end
			default: begin
				push_byte(head0(1'($urandom)));
				push_byte({1'b1, ($urandom_range(0, 1) ? LEN_EXTENDED : 7'd127)});
			end
		endcase
	endtask

	initial begin
		int i;
		logic held;
		held = 1'b0;
		ending = ending_t'($urandom_range(0, 5));
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty frame, all-ones key over zero data, zero key over
		// alternating 00/ff data (key wraps past index 3)
		send_frame(1'b0, 0, $urandom, FILL_RANDOM);
		send_frame(1'b0, 1, 32'hffff_ffff, FILL_ZERO);
		send_frame(1'b0, 5, 32'h0000_0000, FILL_TOGGLE);

		// random text frames; open with one of maximum length
		send_frame(1'b0, MAX_PAYLOAD, $urandom, FILL_RANDOM);
		while (ledger.requests < 720) begin
			if ($urandom_range(0, 5) == 0)
				calm = ~calm;
			if (!held && ledger.requests >= 360) begin
				drain_hold();
				held = 1'b1;
			end
			send_frame(1'b0, draw_len(), $urandom, FILL_RANDOM);
		end
		calm = 1'b0;

		// terminal event, then noise that must all be dropped
		finish_stream();
		for (i = 0; i < 24; i++)
			push_byte(8'($urandom));
		s_axis_tvalid <= 1'b0;

		while (ledger.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Streamed %0d bytes in %0d complete frames; checked %0d results.",
			ledger.requests, frames, ledger.results);
		$display("Stream ended by %s; %0d mismatches.", ending.name(), ledger.mismatches);
		if (ledger.mismatches == 0 && ledger.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: websocket_frame_deframer_unit.f
rtl/wsfd_pkg.sv
rtl/websocket_frame_deframer_unit.sv
sim/testbench.sv
